// ===== hdl/lhs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lhs_pkg
// Shared widths, register map, steering codes and types of the lane
// histogram steering block.
// ----------------------------------------------------------------------------
package lhs_pkg;

  localparam int COL_W   = 9;
  localparam int ROW_W   = 9;
  localparam int FW_W    = 10;
  localparam int CNT_W   = 8;
  localparam int TOTAL_W = 19;
  localparam int OFF_W   = 10;
  localparam int STEER_W = 3;
  localparam int BAND_W  = 8;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;

  localparam int DEF_MAX_COLUMNS = 512;
  localparam int DEF_MAX_ROWS    = 512;
  localparam int COL_LIMIT       = 512;

  localparam logic [CNT_W-1:0]   COUNT_MAX = '1;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  localparam logic [ROW_W-1:0]   RST_BAND_FIRST  = 9'd140;
  localparam logic [BAND_W-1:0]  RST_BAND_ROWS   = 8'd100;
  localparam logic [COL_W-1:0]   RST_LEFT_END    = 9'd149;
  localparam logic [COL_W-1:0]   RST_RIGHT_START = 9'd250;
  localparam logic [FW_W-1:0]    RST_WIDTH       = 10'd400;
  localparam logic [COL_W-1:0]   RST_CENTER      = 9'd188;
  localparam logic [TOTAL_W-1:0] RST_THRESHOLD   = 19'd4500;

  localparam logic [2:0] REG_BAND_FIRST  = 3'd0;
  localparam logic [2:0] REG_BAND_ROWS   = 3'd1;
  localparam logic [2:0] REG_LEFT_END    = 3'd2;
  localparam logic [2:0] REG_RIGHT_START = 3'd3;
  localparam logic [2:0] REG_WIDTH       = 3'd4;
  localparam logic [2:0] REG_CENTER      = 3'd5;
  localparam logic [2:0] REG_THRESHOLD   = 3'd6;

  localparam logic [STEER_W-1:0] STEER_FWD      = 3'd0;
  localparam logic [STEER_W-1:0] STEER_RIGHT_S  = 3'd1;
  localparam logic [STEER_W-1:0] STEER_RIGHT_M  = 3'd2;
  localparam logic [STEER_W-1:0] STEER_RIGHT_L  = 3'd3;
  localparam logic [STEER_W-1:0] STEER_LEFT_S   = 3'd4;
  localparam logic [STEER_W-1:0] STEER_LEFT_M   = 3'd5;
  localparam logic [STEER_W-1:0] STEER_LEFT_L   = 3'd6;
  localparam logic [STEER_W-1:0] STEER_LANE_END = 3'd7;

  localparam logic signed [OFF_W-1:0] OFF_NEAR = 10'sd10;
  localparam logic signed [OFF_W-1:0] OFF_FAR  = 10'sd20;

  typedef struct packed {
    logic [ROW_W-1:0]   band_first_row;
    logic [BAND_W-1:0]  band_rows;
    logic [COL_W-1:0]   left_window_end;
    logic [COL_W-1:0]   right_window_start;
    logic [FW_W-1:0]    frame_width;
    logic [COL_W-1:0]   frame_center;
    logic [TOTAL_W-1:0] lane_end_threshold;
  } cfg_t;

  typedef struct packed {
    logic [COL_W-1:0] left_last;
    logic [COL_W-1:0] right_first;
    logic [COL_W-1:0] right_last;
  } win_t;

  typedef struct packed {
    logic [COL_W-1:0] left_pos;
    logic [COL_W-1:0] right_pos;
  } peak_t;

endpackage

// ===== hdl/lhs_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lhs_ram
// Generic single-clock RAM, one write and one read port, registered read
// returning the old contents on a same-address write.
// ----------------------------------------------------------------------------
module lhs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/lhs_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lhs_cfg
// APB register file holding band, window, width, center and threshold.
// ----------------------------------------------------------------------------
module lhs_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [lhs_pkg::ADDR_W-1:0] paddr,
  input  logic [lhs_pkg::DATA_W-1:0] pwdata,
  output logic [lhs_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output lhs_pkg::cfg_t              cfg
);

  lhs_pkg::cfg_t cfg_r;
  logic          wr_en;
  logic [2:0]    idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.band_first_row     <= lhs_pkg::RST_BAND_FIRST;
      cfg_r.band_rows          <= lhs_pkg::RST_BAND_ROWS;
      cfg_r.left_window_end    <= lhs_pkg::RST_LEFT_END;
      cfg_r.right_window_start <= lhs_pkg::RST_RIGHT_START;
      cfg_r.frame_width        <= lhs_pkg::RST_WIDTH;
      cfg_r.frame_center       <= lhs_pkg::RST_CENTER;
      cfg_r.lane_end_threshold <= lhs_pkg::RST_THRESHOLD;
    end else if (wr_en) begin
      case (idx)
        lhs_pkg::REG_BAND_FIRST:  cfg_r.band_first_row     <= pwdata[lhs_pkg::ROW_W-1:0];
        lhs_pkg::REG_BAND_ROWS:   cfg_r.band_rows          <= pwdata[lhs_pkg::BAND_W-1:0];
        lhs_pkg::REG_LEFT_END:    cfg_r.left_window_end    <= pwdata[lhs_pkg::COL_W-1:0];
        lhs_pkg::REG_RIGHT_START: cfg_r.right_window_start <= pwdata[lhs_pkg::COL_W-1:0];
        lhs_pkg::REG_WIDTH:       cfg_r.frame_width        <= pwdata[lhs_pkg::FW_W-1:0];
        lhs_pkg::REG_CENTER:      cfg_r.frame_center       <= pwdata[lhs_pkg::COL_W-1:0];
        lhs_pkg::REG_THRESHOLD:   cfg_r.lane_end_threshold <= pwdata[lhs_pkg::TOTAL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      lhs_pkg::REG_BAND_FIRST:  prdata = 32'(cfg_r.band_first_row);
      lhs_pkg::REG_BAND_ROWS:   prdata = 32'(cfg_r.band_rows);
      lhs_pkg::REG_LEFT_END:    prdata = 32'(cfg_r.left_window_end);
      lhs_pkg::REG_RIGHT_START: prdata = 32'(cfg_r.right_window_start);
      lhs_pkg::REG_WIDTH:       prdata = 32'(cfg_r.frame_width);
      lhs_pkg::REG_CENTER:      prdata = 32'(cfg_r.frame_center);
      lhs_pkg::REG_THRESHOLD:   prdata = 32'(cfg_r.lane_end_threshold);
      default:                  prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

// ===== hdl/lhs_peak.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lhs_peak
// Tracks the first column with the largest count in the left and right
// windows while the column store is swept in ascending order.
// ----------------------------------------------------------------------------
module lhs_peak (
  input  logic                      clk,
  input  logic                      d_valid,
  input  logic [lhs_pkg::COL_W-1:0] d_col,
  input  logic [lhs_pkg::CNT_W-1:0] d_cnt,
  input  lhs_pkg::win_t             win,
  output lhs_pkg::peak_t            peak
);

  logic [lhs_pkg::CNT_W-1:0] lcnt_r;
  logic [lhs_pkg::CNT_W-1:0] rcnt_r;
  logic [lhs_pkg::COL_W-1:0] lpos_r;
  logic [lhs_pkg::COL_W-1:0] rpos_r;
  logic                      in_left;
  logic                      in_right;

  assign in_left  = d_col <= win.left_last;
  assign in_right = (d_col >= win.right_first) && (d_col <= win.right_last);

  // first column of a window always seeds the peak
  always_ff @(posedge clk) begin
    if (d_valid) begin
      if (in_left && ((d_col == '0) || (d_cnt > lcnt_r))) begin
        lcnt_r <= d_cnt;
        lpos_r <= d_col;
      end
      if (in_right && ((d_col == win.right_first) || (d_cnt > rcnt_r))) begin
        rcnt_r <= d_cnt;
        rpos_r <= d_col;
      end
    end
  end

  assign peak.left_pos  = lpos_r;
  assign peak.right_pos = rpos_r;

endmodule

// ===== hdl/lane_histogram_steering.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lane_histogram_steering
// Column histogram lane finder with peak search and steering code output.
// ----------------------------------------------------------------------------
// Pixels are taken one per clock in raster order; each counted pixel does a
// read-modify-write of its column in the count RAM, with a one-entry forward
// path so consecutive hits on one column keep counting. The item flagged as
// the frame's last starts a sweep of min(MAX_COLUMNS, 512) RAM reads that
// finds both peaks and clears each column behind it; input stalls after the
// last item through that sweep and the drain, middle and emit steps,
// longer while an earlier result still waits to be taken, and the result
// then waits in an output register while the next frame streams in. After
// reset the same sweep clears the RAM before the first pixel is taken.
// ----------------------------------------------------------------------------
module lane_histogram_steering #(
  parameter int MAX_COLUMNS = lhs_pkg::DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = lhs_pkg::DEF_MAX_ROWS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [lhs_pkg::ADDR_W-1:0]         paddr,
  input  logic [lhs_pkg::DATA_W-1:0]         pwdata,
  output logic [lhs_pkg::DATA_W-1:0]         prdata,
  output logic                               pready,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_pixel_on,
  input  logic [lhs_pkg::ROW_W-1:0]          in_pixel_row,
  input  logic [lhs_pkg::COL_W-1:0]          in_pixel_col,
  input  logic                               in_frame_last,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [lhs_pkg::COL_W-1:0]          out_left_pos,
  output logic [lhs_pkg::COL_W-1:0]          out_right_pos,
  output logic [lhs_pkg::COL_W-1:0]          out_lane_mid,
  output logic signed [lhs_pkg::OFF_W-1:0]   out_offset,
  output logic [lhs_pkg::TOTAL_W-1:0]        out_set_total,
  output logic                               out_lane_end,
  output logic [lhs_pkg::STEER_W-1:0]        out_steer_code
);

  localparam int AW     = $clog2(MAX_COLUMNS);
  localparam int SCAN_N = (MAX_COLUMNS < lhs_pkg::COL_LIMIT) ? MAX_COLUMNS
                                                             : lhs_pkg::COL_LIMIT;
  localparam logic [lhs_pkg::FW_W-1:0] WIDTH_LIM = lhs_pkg::FW_W'(SCAN_N);
  localparam logic [lhs_pkg::FW_W-1:0] SCAN_LAST = lhs_pkg::FW_W'(SCAN_N - 1);

  typedef enum logic [2:0] {
    ST_INIT, ST_RUN, ST_SCAN, ST_DRAIN, ST_MID, ST_EMIT
  } state_t;

  lhs_pkg::cfg_t  cfg;
  lhs_pkg::win_t  win;
  lhs_pkg::peak_t peak;

  state_t                       state_r;
  logic [lhs_pkg::FW_W-1:0]     sc_r;
  logic                         d_valid_r;
  logic [lhs_pkg::COL_W-1:0]    d_col_r;

  logic                         s1_inc_r;
  logic                         s1_last_r;
  logic [lhs_pkg::COL_W-1:0]    s1_col_r;
  logic                         fw_hit_r;
  logic [lhs_pkg::COL_W-1:0]    fw_col_r;
  logic [lhs_pkg::CNT_W-1:0]    fw_val_r;
  logic [lhs_pkg::TOTAL_W-1:0]  total_r;
  logic [lhs_pkg::COL_W-1:0]    mid_r;

  logic                         out_valid_r;
  logic [lhs_pkg::COL_W-1:0]    left_pos_r;
  logic [lhs_pkg::COL_W-1:0]    right_pos_r;
  logic [lhs_pkg::COL_W-1:0]    lane_mid_r;
  logic signed [lhs_pkg::OFF_W-1:0] offset_r;
  logic [lhs_pkg::TOTAL_W-1:0]  set_total_r;
  logic                         lane_end_r;
  logic [lhs_pkg::STEER_W-1:0]  steer_r;

  logic                         acc;
  logic                         in_band;
  logic                         counted;
  logic [lhs_pkg::ROW_W-1:0]    row_rel;
  logic [lhs_pkg::FW_W-1:0]     width_eff;
  logic [lhs_pkg::COL_W-1:0]    width_last;
  logic [lhs_pkg::CNT_W-1:0]    rd_cnt;
  logic [lhs_pkg::CNT_W-1:0]    cur_cnt;
  logic [lhs_pkg::CNT_W-1:0]    new_cnt;
  logic                         ram_we;
  logic [AW-1:0]                ram_waddr;
  logic [AW-1:0]                ram_raddr;
  logic [lhs_pkg::CNT_W-1:0]    ram_wdata;
  logic signed [lhs_pkg::OFF_W-1:0] diff;
  logic signed [lhs_pkg::OFF_W-1:0] diff_adj;
  logic signed [lhs_pkg::OFF_W-1:0] half;
  logic signed [lhs_pkg::OFF_W-1:0] off;
  logic                         lane_end;
  logic [lhs_pkg::STEER_W-1:0]  steer;
  logic                         out_free;

  lhs_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // effective width and search windows
  always_comb begin
    if (cfg.frame_width == '0) begin
      width_eff = lhs_pkg::FW_W'(1);
    end else if (cfg.frame_width > WIDTH_LIM) begin
      width_eff = WIDTH_LIM;
    end else begin
      width_eff = cfg.frame_width;
    end
  end

  assign width_last      = lhs_pkg::COL_W'(width_eff - lhs_pkg::FW_W'(1));
  assign win.left_last   = ({1'b0, cfg.left_window_end} < width_eff) ?
                           cfg.left_window_end : width_last;
  assign win.right_first = ({1'b0, cfg.right_window_start} < width_eff) ?
                           cfg.right_window_start : width_last;
  assign win.right_last  = width_last;

  // pixel front end
  assign in_stall = (state_r != ST_RUN) || s1_last_r;
  assign acc      = in_valid && !in_stall;
  assign row_rel  = in_pixel_row - cfg.band_first_row;
  assign in_band  = (in_pixel_row >= cfg.band_first_row) &&
                    (row_rel < {1'b0, cfg.band_rows}) &&
                    (32'(in_pixel_row) < MAX_ROWS);
  assign counted  = in_pixel_on && in_band && ({1'b0, in_pixel_col} < width_eff);

  assign cur_cnt  = (fw_hit_r && (fw_col_r == s1_col_r)) ? fw_val_r : rd_cnt;
  assign new_cnt  = (cur_cnt == lhs_pkg::COUNT_MAX) ? cur_cnt
                                                    : cur_cnt + lhs_pkg::CNT_W'(1);

  always_comb begin
    if (state_r == ST_RUN) begin
      ram_we    = s1_inc_r;
      ram_waddr = AW'(s1_col_r);
      ram_wdata = new_cnt;
      ram_raddr = AW'(in_pixel_col);
    end else begin
      ram_we    = (state_r == ST_SCAN) || (state_r == ST_INIT);
      ram_waddr = AW'(sc_r);
      ram_wdata = '0;
      ram_raddr = AW'(sc_r);
    end
  end

  lhs_ram #(
    .WIDTH (lhs_pkg::CNT_W),
    .DEPTH (MAX_COLUMNS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rd_cnt)
  );

  lhs_peak u_peak (
    .clk     (clk),
    .d_valid (d_valid_r),
    .d_col   (d_col_r),
    .d_cnt   (rd_cnt),
    .win     (win),
    .peak    (peak)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_inc_r  <= 1'b0;
      s1_last_r <= 1'b0;
      fw_hit_r  <= 1'b0;
      total_r   <= '0;
    end else begin
      s1_inc_r  <= acc && counted;
      s1_last_r <= acc && in_frame_last;
      fw_hit_r  <= (state_r == ST_RUN) && s1_inc_r;
      if (state_r == ST_EMIT && out_free) begin
        total_r <= '0;
      end else if (acc && in_pixel_on && (total_r != lhs_pkg::TOTAL_MAX)) begin
        total_r <= total_r + lhs_pkg::TOTAL_W'(1);
      end
    end
    s1_col_r <= in_pixel_col;
    fw_col_r <= s1_col_r;
    fw_val_r <= new_cnt;
  end

  // lane middle, offset and steering
  assign diff     = $signed({1'b0, peak.right_pos}) - $signed({1'b0, peak.left_pos});
  assign diff_adj = diff + $signed({{(lhs_pkg::OFF_W-1){1'b0}}, diff[lhs_pkg::OFF_W-1]});
  assign half     = diff_adj >>> 1;
  assign off      = $signed({1'b0, mid_r}) - $signed({1'b0, cfg.frame_center});
  assign lane_end = total_r > cfg.lane_end_threshold;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    if (lane_end) begin
      steer = lhs_pkg::STEER_LANE_END;
    end else if (off == '0) begin
      steer = lhs_pkg::STEER_FWD;
    end else if (!off[lhs_pkg::OFF_W-1]) begin
      if (off < lhs_pkg::OFF_NEAR) begin
        steer = lhs_pkg::STEER_RIGHT_S;
      end else if (off < lhs_pkg::OFF_FAR) begin
        steer = lhs_pkg::STEER_RIGHT_M;
      end else begin
        steer = lhs_pkg::STEER_RIGHT_L;
      end
    end else begin
      if (off > -lhs_pkg::OFF_NEAR) begin
        steer = lhs_pkg::STEER_LEFT_S;
      end else if (off > -lhs_pkg::OFF_FAR) begin
        steer = lhs_pkg::STEER_LEFT_M;
      end else begin
        steer = lhs_pkg::STEER_LEFT_L;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      sc_r        <= '0;
      d_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      d_valid_r <= (state_r == ST_SCAN);
      if (state_r == ST_EMIT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_INIT: begin
          if (sc_r == SCAN_LAST) begin
            sc_r    <= '0;
            state_r <= ST_RUN;
          end else begin
            sc_r <= sc_r + lhs_pkg::FW_W'(1);
          end
        end
        ST_RUN: begin
          if (s1_last_r) begin
            sc_r    <= '0;
            state_r <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          sc_r <= sc_r + lhs_pkg::FW_W'(1);
          if (sc_r == SCAN_LAST) begin
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          state_r <= ST_MID;
        end
        ST_MID: begin
          mid_r   <= peak.left_pos + half[lhs_pkg::COL_W-1:0];
          state_r <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            left_pos_r  <= peak.left_pos;
            right_pos_r <= peak.right_pos;
            lane_mid_r  <= mid_r;
            offset_r    <= off;
            set_total_r <= total_r;
            lane_end_r  <= lane_end;
            steer_r     <= steer;
            state_r     <= ST_RUN;
          end
        end
        default: begin
          state_r <= ST_INIT;
        end
      endcase
    end
    d_col_r <= sc_r[lhs_pkg::COL_W-1:0];
  end

  assign out_valid      = out_valid_r;
  assign out_left_pos   = left_pos_r;
  assign out_right_pos  = right_pos_r;
  assign out_lane_mid   = lane_mid_r;
  assign out_offset     = offset_r;
  assign out_set_total  = set_total_r;
  assign out_lane_end   = lane_end_r;
  assign out_steer_code = steer_r;

  a_last_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_frame_last |=> in_stall)
    else $error("input taken right after the last pixel of a frame");

  a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_EMIT))
    else $error("result raised outside the emit step");

  a_count_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) && ram_we |-> ({1'b0, s1_col_r} < width_eff))
    else $error("column count written outside the frame width");

endmodule
